// File: src/sbr_pkg.sv
package sbr_pkg;

  // Default number of fraction bits of the segment parameter.
  localparam int unsigned PARAM_FRAC_BITS_DEF = 16;

  // Port field widths.
  localparam int unsigned COORD_W = 24;
  localparam int unsigned SIZE_W  = 23;
  localparam int unsigned GROUP_W = 5;
  localparam int unsigned DIST_W  = 24;

  // Internal widths; coordinates carry one extra fraction bit (Q.9).
  localparam int unsigned Q9_W    = COORD_W + 1;
  localparam int unsigned HALF_W  = COORD_W + 1;
  localparam int unsigned EDGE_W  = Q9_W + 1;
  localparam int unsigned A_W     = Q9_W + 1;
  localparam int unsigned NUM_W   = EDGE_W + 1;
  localparam int unsigned LEN_W   = SIZE_W + 1;
  localparam int unsigned PROD_W  = A_W + NUM_W;
  localparam int unsigned CROSS_W = PROD_W + 1;
  localparam int unsigned LIM_W   = LEN_W + A_W;
  localparam int unsigned DIVD_W  = A_W;
  localparam int unsigned REMD_W  = DIVD_W + 1;
  localparam int unsigned RX_W    = COORD_W + 2;
  localparam int unsigned SQ_W    = 2 * COORD_W + 1;
  localparam int unsigned DSQ_W   = SQ_W + 1;
  localparam int unsigned ROOT_W  = DSQ_W / 2;
  localparam int unsigned REMS_W  = ROOT_W + 3;

  // Iterations of the divider and of the square root done in one stage.
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned SQRT_STEPS = 4;

  // Box edges, in the order in which ties are resolved.
  localparam int unsigned NUM_EDGES   = 4;
  localparam int unsigned EDGE_LEFT   = 0;
  localparam int unsigned EDGE_RIGHT  = 1;
  localparam int unsigned EDGE_TOP    = 2;
  localparam int unsigned EDGE_BOTTOM = 3;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

endpackage

// File: src/segment_box_raycast_unit.sv
// Channel | Direction | Handshake              | Word
// query   | in        | in_valid_i/in_ready_o   | segment, box, groups
// result  | out       | out_valid_o/out_ready_i | hit, hit point, distance
//
// One word per cycle is accepted while no stall backs up to the input. The number
// of stages is set by the restoring divider for the segment parameter (four
// quotient bits a stage) and the square root (four root bits a stage).
// Reset clears only the valid bits of the stages.
// Each stage holds its word while the stage after it is full and stalled, so a
// stall at the output backs up stage by stage and empty stages keep filling.
module segment_box_raycast_unit #(
  parameter int unsigned PARAM_FRAC_BITS = sbr_pkg::PARAM_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [sbr_pkg::COORD_W-1:0]  start_x_i,
  input  logic signed [sbr_pkg::COORD_W-1:0]  start_y_i,
  input  logic signed [sbr_pkg::COORD_W-1:0]  end_x_i,
  input  logic signed [sbr_pkg::COORD_W-1:0]  end_y_i,
  input  logic signed [sbr_pkg::COORD_W-1:0]  box_center_x_i,
  input  logic signed [sbr_pkg::COORD_W-1:0]  box_center_y_i,
  input  logic        [sbr_pkg::SIZE_W-1:0]   box_width_i,
  input  logic        [sbr_pkg::SIZE_W-1:0]   box_height_i,
  input  logic        [sbr_pkg::GROUP_W-1:0]  segment_group_i,
  input  logic        [sbr_pkg::GROUP_W-1:0]  box_group_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                hit_o,
  output logic signed [sbr_pkg::COORD_W-1:0]  hit_x_o,
  output logic signed [sbr_pkg::COORD_W-1:0]  hit_y_o,
  output logic        [sbr_pkg::DIST_W-1:0]   hit_distance_o
);

  localparam int unsigned E        = sbr_pkg::NUM_EDGES;
  localparam int unsigned QuotW    = PARAM_FRAC_BITS + 1;
  localparam int unsigned MixW     = QuotW + 1 + sbr_pkg::HALF_W;
  localparam int unsigned NumDiv   = (QuotW + sbr_pkg::DIV_STEPS - 1) / sbr_pkg::DIV_STEPS;
  localparam int unsigned NumSqrt  =
      (sbr_pkg::ROOT_W + sbr_pkg::SQRT_STEPS - 1) / sbr_pkg::SQRT_STEPS;
  localparam int unsigned StPrep   = 0;
  localparam int unsigned StMul    = 1;
  localparam int unsigned StChk    = 2;
  localparam int unsigned StDiv0   = 3;
  localparam int unsigned StMix    = StDiv0 + NumDiv;
  localparam int unsigned StRnd    = StMix + 1;
  localparam int unsigned StSq     = StMix + 2;
  localparam int unsigned StSum    = StMix + 3;
  localparam int unsigned StPair   = StMix + 4;
  localparam int unsigned StBest   = StMix + 5;
  localparam int unsigned StSqrt0  = StMix + 6;
  localparam int unsigned StOut    = StSqrt0 + NumSqrt;
  localparam int unsigned NumSt    = StOut + 1;

  // Stage words.
  typedef struct packed {
    logic                                        match;
    logic signed [sbr_pkg::COORD_W-1:0]          sx;
    logic signed [sbr_pkg::COORD_W-1:0]          sy;
    logic signed [sbr_pkg::HALF_W-1:0]           dxh;
    logic signed [sbr_pkg::HALF_W-1:0]           dyh;
    logic signed [sbr_pkg::A_W-1:0]              dx;
    logic signed [sbr_pkg::A_W-1:0]              dy;
    logic [E-1:0][sbr_pkg::NUM_W-1:0]            num;
    logic signed [sbr_pkg::NUM_W-1:0]            off_v;
    logic signed [sbr_pkg::NUM_W-1:0]            off_h;
    logic [sbr_pkg::LEN_W-1:0]                   len_v;
    logic [sbr_pkg::LEN_W-1:0]                   len_h;
  } prep_t;

  typedef struct packed {
    logic                                        match;
    logic signed [sbr_pkg::COORD_W-1:0]          sx;
    logic signed [sbr_pkg::COORD_W-1:0]          sy;
    logic signed [sbr_pkg::HALF_W-1:0]           dxh;
    logic signed [sbr_pkg::HALF_W-1:0]           dyh;
    logic [E-1:0][sbr_pkg::PROD_W-1:0]           p1;
    logic [E-1:0][sbr_pkg::PROD_W-1:0]           p2;
    logic [E-1:0]                                neg;
    logic [E-1:0]                                sn_ok;
    logic [E-1:0]                                full;
    logic [E-1:0][sbr_pkg::DIVD_W-1:0]           dvd;
    logic [E-1:0][sbr_pkg::DIVD_W-1:0]           dvs;
    logic [sbr_pkg::LIM_W-1:0]                   lim_v;
    logic [sbr_pkg::LIM_W-1:0]                   lim_h;
  } mul_t;

  typedef struct packed {
    logic [E-1:0]                                hit;
    logic [E-1:0]                                full;
    logic [E-1:0][sbr_pkg::REMD_W-1:0]           rem;
    logic [E-1:0][QuotW-1:0]                     quo;
    logic [E-1:0][sbr_pkg::DIVD_W-1:0]           dvs;
    logic signed [sbr_pkg::COORD_W-1:0]          sx;
    logic signed [sbr_pkg::COORD_W-1:0]          sy;
    logic signed [sbr_pkg::HALF_W-1:0]           dxh;
    logic signed [sbr_pkg::HALF_W-1:0]           dyh;
  } div_t;

  typedef struct packed {
    logic [E-1:0]                                hit;
    logic [E-1:0][MixW-1:0]                      mx;
    logic [E-1:0][MixW-1:0]                      my;
    logic signed [sbr_pkg::COORD_W-1:0]          sx;
    logic signed [sbr_pkg::COORD_W-1:0]          sy;
  } mix_t;

  typedef struct packed {
    logic [E-1:0]                                hit;
    logic [E-1:0][sbr_pkg::RX_W-1:0]             rx;
    logic [E-1:0][sbr_pkg::RX_W-1:0]             ry;
    logic signed [sbr_pkg::COORD_W-1:0]          sx;
    logic signed [sbr_pkg::COORD_W-1:0]          sy;
  } rnd_t;

  typedef struct packed {
    logic [E-1:0]                                hit;
    logic [E-1:0][sbr_pkg::SQ_W-1:0]             sqx;
    logic [E-1:0][sbr_pkg::SQ_W-1:0]             sqy;
    logic [E-1:0][sbr_pkg::COORD_W-1:0]          px;
    logic [E-1:0][sbr_pkg::COORD_W-1:0]          py;
  } sq_t;

  typedef struct packed {
    logic                                        hit;
    logic [sbr_pkg::DSQ_W-1:0]                   dsq;
    logic [sbr_pkg::COORD_W-1:0]                 px;
    logic [sbr_pkg::COORD_W-1:0]                 py;
  } cand_t;

  typedef struct packed {
    logic                                        found;
    logic [sbr_pkg::COORD_W-1:0]                 px;
    logic [sbr_pkg::COORD_W-1:0]                 py;
    logic [sbr_pkg::DSQ_W-1:0]                   val;
    logic [sbr_pkg::REMS_W-1:0]                  rem;
    logic [sbr_pkg::ROOT_W-1:0]                  root;
  } sqrt_t;

  // Keeps the earlier candidate on a tie.
  function automatic cand_t pick(cand_t a, cand_t b);
    cand_t r;
    r = a;
    if (b.hit && (!a.hit || (b.dsq < a.dsq))) begin
      r = b;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stage flow control: a stage loads when it is empty or the next one loads.
  // ---------------------------------------------------------------------------
  logic [NumSt-1:0] vld_q;
  logic [NumSt-1:0] vld_d;
  logic [NumSt-1:0] vld_in;
  logic [NumSt:0]   adv;

  assign adv[NumSt] = out_ready_i;
  for (genvar k = 0; k < NumSt; k++) begin : g_adv
    assign adv[k] = ~vld_q[k] | adv[k+1];
  end

  assign vld_in = {vld_q[NumSt-2:0], in_valid_i};
  assign vld_d  = (vld_in & adv[NumSt-1:0]) | (vld_q & ~adv[NumSt-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = adv[StPrep];
  assign out_valid_o = vld_q[StOut];

  // ---------------------------------------------------------------------------
  // Prep: Q.9 coordinates, box edges, and for each edge the numerator of the
  // segment parameter. Vertical edges test x, horizontal edges test y.
  // ---------------------------------------------------------------------------
  prep_t prep_d, prep_q;
  logic signed [sbr_pkg::Q9_W-1:0]   x1, y1, x2, y2, cx2, cy2;
  logic signed [sbr_pkg::EDGE_W-1:0] lft, rgt, top, bot;

  always_comb begin
    x1  = {start_x_i, 1'b0};
    y1  = {start_y_i, 1'b0};
    x2  = {end_x_i, 1'b0};
    y2  = {end_y_i, 1'b0};
    cx2 = {box_center_x_i, 1'b0};
    cy2 = {box_center_y_i, 1'b0};
    lft = sbr_pkg::EDGE_W'(cx2) - $signed(sbr_pkg::EDGE_W'(box_width_i));
    rgt = sbr_pkg::EDGE_W'(cx2) + $signed(sbr_pkg::EDGE_W'(box_width_i));
    top = sbr_pkg::EDGE_W'(cy2) - $signed(sbr_pkg::EDGE_W'(box_height_i));
    bot = sbr_pkg::EDGE_W'(cy2) + $signed(sbr_pkg::EDGE_W'(box_height_i));

    prep_d.match = (segment_group_i == box_group_i);
    prep_d.sx    = start_x_i;
    prep_d.sy    = start_y_i;
    prep_d.dxh   = sbr_pkg::HALF_W'(end_x_i) - sbr_pkg::HALF_W'(start_x_i);
    prep_d.dyh   = sbr_pkg::HALF_W'(end_y_i) - sbr_pkg::HALF_W'(start_y_i);
    prep_d.dx    = sbr_pkg::A_W'(x2) - sbr_pkg::A_W'(x1);
    prep_d.dy    = sbr_pkg::A_W'(y2) - sbr_pkg::A_W'(y1);
    prep_d.num[sbr_pkg::EDGE_LEFT]   = sbr_pkg::NUM_W'(lft) - sbr_pkg::NUM_W'(x1);
    prep_d.num[sbr_pkg::EDGE_RIGHT]  = sbr_pkg::NUM_W'(rgt) - sbr_pkg::NUM_W'(x1);
    prep_d.num[sbr_pkg::EDGE_TOP]    = sbr_pkg::NUM_W'(top) - sbr_pkg::NUM_W'(y1);
    prep_d.num[sbr_pkg::EDGE_BOTTOM] = sbr_pkg::NUM_W'(bot) - sbr_pkg::NUM_W'(y1);
    prep_d.off_v = sbr_pkg::NUM_W'(y1) - sbr_pkg::NUM_W'(top);
    prep_d.off_h = sbr_pkg::NUM_W'(x1) - sbr_pkg::NUM_W'(lft);
    prep_d.len_v = {box_height_i, 1'b0};
    prep_d.len_h = {box_width_i, 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (adv[StPrep]) begin
      prep_q <= prep_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Multiply: the crossing test along the edge is a two-term cross product that
  // must lie between zero and the edge length times the segment extent.
  // ---------------------------------------------------------------------------
  mul_t mul_d, mul_q;

  always_comb begin
    logic                             vert;
    logic signed [sbr_pkg::A_W-1:0]   a, b;
    logic signed [sbr_pkg::NUM_W-1:0] off, numk, sn;
    logic [sbr_pkg::LEN_W-1:0]        len;
    logic [sbr_pkg::A_W-1:0]          absa, abs_dx, abs_dy;
    abs_dx = prep_q.dx[sbr_pkg::A_W-1] ? sbr_pkg::A_W'(-prep_q.dx) : prep_q.dx;
    abs_dy = prep_q.dy[sbr_pkg::A_W-1] ? sbr_pkg::A_W'(-prep_q.dy) : prep_q.dy;
    mul_d.match = prep_q.match;
    mul_d.sx    = prep_q.sx;
    mul_d.sy    = prep_q.sy;
    mul_d.dxh   = prep_q.dxh;
    mul_d.dyh   = prep_q.dyh;
    mul_d.lim_v = sbr_pkg::LIM_W'(prep_q.len_v) * sbr_pkg::LIM_W'(abs_dx);
    mul_d.lim_h = sbr_pkg::LIM_W'(prep_q.len_h) * sbr_pkg::LIM_W'(abs_dy);
    for (int k = 0; k < E; k++) begin
      vert = (k == sbr_pkg::EDGE_LEFT) || (k == sbr_pkg::EDGE_RIGHT);
      a    = vert ? prep_q.dx : prep_q.dy;
      b    = vert ? prep_q.dy : prep_q.dx;
      off  = vert ? prep_q.off_v : prep_q.off_h;
      len  = vert ? prep_q.len_v : prep_q.len_h;
      absa = vert ? abs_dx : abs_dy;
      numk = $signed(prep_q.num[k]);
      sn   = a[sbr_pkg::A_W-1] ? sbr_pkg::NUM_W'(-numk) : numk;
      mul_d.neg[k]   = a[sbr_pkg::A_W-1];
      mul_d.sn_ok[k] = (a != '0) && (len != '0) && !sn[sbr_pkg::NUM_W-1] &&
                       (sn <= $signed({1'b0, absa}));
      mul_d.full[k]  = (sn == $signed({1'b0, absa}));
      mul_d.dvd[k]   = sn[sbr_pkg::DIVD_W-1:0];
      mul_d.dvs[k]   = absa;
      mul_d.p1[k]    = sbr_pkg::PROD_W'(a) * sbr_pkg::PROD_W'(off);
      mul_d.p2[k]    = sbr_pkg::PROD_W'(b) * sbr_pkg::PROD_W'(numk);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[StMul]) begin
      mul_q <= mul_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Check: sum the cross product and compare it against the limit, on the side
  // given by the sign of the denominator.
  // ---------------------------------------------------------------------------
  div_t chk_d, chk_q;

  always_comb begin
    logic signed [sbr_pkg::CROSS_W-1:0] xprod, limc;
    logic                               vert, ok;
    chk_d.sx  = mul_q.sx;
    chk_d.sy  = mul_q.sy;
    chk_d.dxh = mul_q.dxh;
    chk_d.dyh = mul_q.dyh;
    for (int k = 0; k < E; k++) begin
      vert  = (k == sbr_pkg::EDGE_LEFT) || (k == sbr_pkg::EDGE_RIGHT);
      xprod = sbr_pkg::CROSS_W'($signed(mul_q.p1[k])) +
              sbr_pkg::CROSS_W'($signed(mul_q.p2[k]));
      limc  = $signed(sbr_pkg::CROSS_W'(vert ? mul_q.lim_v : mul_q.lim_h));
      if (mul_q.neg[k]) begin
        ok = (xprod <= 0) && (xprod >= -limc);
      end else begin
        ok = (xprod >= 0) && (xprod <= limc);
      end
      chk_d.hit[k]  = mul_q.match && mul_q.sn_ok[k] && ok;
      chk_d.full[k] = mul_q.full[k];
      chk_d.rem[k]  = sbr_pkg::REMD_W'(mul_q.dvd[k]);
      chk_d.quo[k]  = '0;
      chk_d.dvs[k]  = mul_q.dvs[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[StChk]) begin
      chk_q <= chk_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Restoring divider for the segment parameter, a few quotient bits a stage.
  // ---------------------------------------------------------------------------
  div_t div_in [NumDiv];
  div_t div_d  [NumDiv];
  div_t div_q  [NumDiv];

  for (genvar j = 0; j < NumDiv; j++) begin : g_div
    if (j == 0) begin : g_first
      assign div_in[j] = chk_q;
    end else begin : g_next
      assign div_in[j] = div_q[j-1];
    end

    always_comb begin
      logic [sbr_pkg::REMD_W-1:0] r2;
      div_d[j] = div_in[j];
      for (int i = 0; i < sbr_pkg::DIV_STEPS; i++) begin
        if (j * sbr_pkg::DIV_STEPS + i < QuotW) begin
          for (int e = 0; e < E; e++) begin
            r2 = {div_d[j].rem[e][sbr_pkg::REMD_W-2:0], 1'b0};
            if (r2 >= sbr_pkg::REMD_W'(div_d[j].dvs[e])) begin
              div_d[j].rem[e] = r2 - sbr_pkg::REMD_W'(div_d[j].dvs[e]);
              div_d[j].quo[e] = {div_d[j].quo[e][QuotW-2:0], 1'b1};
            end else begin
              div_d[j].rem[e] = r2;
              div_d[j].quo[e] = {div_d[j].quo[e][QuotW-2:0], 1'b0};
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[StDiv0+j]) begin
        div_q[j] <= div_d[j];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Mix: round the quotient to the parameter and scale the segment extent.
  // ---------------------------------------------------------------------------
  mix_t mix_d, mix_q;

  always_comb begin
    logic [QuotW:0]   qinc;
    logic [QuotW-1:0] ua;
    mix_d.hit = div_q[NumDiv-1].hit;
    mix_d.sx  = div_q[NumDiv-1].sx;
    mix_d.sy  = div_q[NumDiv-1].sy;
    for (int e = 0; e < E; e++) begin
      qinc = {1'b0, div_q[NumDiv-1].quo[e]} + 1'b1;
      ua   = div_q[NumDiv-1].full[e] ? (QuotW'(1) << PARAM_FRAC_BITS) : qinc[QuotW:1];
      mix_d.mx[e] = MixW'($signed({1'b0, ua})) * MixW'(div_q[NumDiv-1].dxh);
      mix_d.my[e] = MixW'($signed({1'b0, ua})) * MixW'(div_q[NumDiv-1].dyh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[StMix]) begin
      mix_q <= mix_d;
    end
  end

  // Round to nearest, ties toward plus infinity.
  rnd_t rnd_d, rnd_q;

  always_comb begin
    logic signed [MixW-1:0] tx, ty;
    rnd_d.hit = mix_q.hit;
    rnd_d.sx  = mix_q.sx;
    rnd_d.sy  = mix_q.sy;
    for (int e = 0; e < E; e++) begin
      tx = ($signed(mix_q.mx[e]) + $signed(MixW'(1) << (PARAM_FRAC_BITS - 1)))
           >>> PARAM_FRAC_BITS;
      ty = ($signed(mix_q.my[e]) + $signed(MixW'(1) << (PARAM_FRAC_BITS - 1)))
           >>> PARAM_FRAC_BITS;
      rnd_d.rx[e] = tx[sbr_pkg::RX_W-1:0];
      rnd_d.ry[e] = ty[sbr_pkg::RX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[StRnd]) begin
      rnd_q <= rnd_d;
    end
  end

  // Square the offsets and form the hit points.
  sq_t sq_d, sq_q;

  always_comb begin
    logic signed [2*sbr_pkg::RX_W-1:0] sx2, sy2;
    sq_d.hit = rnd_q.hit;
    for (int e = 0; e < E; e++) begin
      sx2 = $signed(rnd_q.rx[e]) * $signed(rnd_q.rx[e]);
      sy2 = $signed(rnd_q.ry[e]) * $signed(rnd_q.ry[e]);
      sq_d.sqx[e] = sx2[sbr_pkg::SQ_W-1:0];
      sq_d.sqy[e] = sy2[sbr_pkg::SQ_W-1:0];
      sq_d.px[e]  = rnd_q.sx + rnd_q.rx[e][sbr_pkg::COORD_W-1:0];
      sq_d.py[e]  = rnd_q.sy + rnd_q.ry[e][sbr_pkg::COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[StSq]) begin
      sq_q <= sq_d;
    end
  end

  cand_t [E-1:0] sum_d, sum_q;

  always_comb begin
    for (int e = 0; e < E; e++) begin
      sum_d[e].hit = sq_q.hit[e];
      sum_d[e].dsq = sbr_pkg::DSQ_W'(sq_q.sqx[e]) + sbr_pkg::DSQ_W'(sq_q.sqy[e]);
      sum_d[e].px  = sq_q.px[e];
      sum_d[e].py  = sq_q.py[e];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[StSum]) begin
      sum_q <= sum_d;
    end
  end

  // Closest hit over a two-level tree; the earlier edge wins a tie.
  cand_t [1:0] pair_d, pair_q;
  cand_t       best_d, best_q;

  assign pair_d[0] = pick(sum_q[sbr_pkg::EDGE_LEFT], sum_q[sbr_pkg::EDGE_RIGHT]);
  assign pair_d[1] = pick(sum_q[sbr_pkg::EDGE_TOP], sum_q[sbr_pkg::EDGE_BOTTOM]);
  assign best_d    = pick(pair_q[0], pair_q[1]);

  always_ff @(posedge clk_i) begin
    if (adv[StPair]) begin
      pair_q <= pair_d;
    end
    if (adv[StBest]) begin
      best_q <= best_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Digit-by-digit square root of the squared distance, a few bits a stage.
  // ---------------------------------------------------------------------------
  sqrt_t sqrt_in [NumSqrt];
  sqrt_t sqrt_d  [NumSqrt];
  sqrt_t sqrt_q  [NumSqrt];

  for (genvar j = 0; j < NumSqrt; j++) begin : g_sqrt
    if (j == 0) begin : g_first
      assign sqrt_in[j] = '{found: best_q.hit, px: best_q.px, py: best_q.py,
                            val: best_q.dsq, rem: '0, root: '0};
    end else begin : g_next
      assign sqrt_in[j] = sqrt_q[j-1];
    end

    always_comb begin
      logic [sbr_pkg::REMS_W-1:0] trial;
      sqrt_d[j] = sqrt_in[j];
      for (int i = 0; i < sbr_pkg::SQRT_STEPS; i++) begin
        if (j * sbr_pkg::SQRT_STEPS + i < sbr_pkg::ROOT_W) begin
          sqrt_d[j].rem = {sqrt_d[j].rem[sbr_pkg::REMS_W-3:0],
                           sqrt_d[j].val[sbr_pkg::DSQ_W-1 -: 2]};
          sqrt_d[j].val = sqrt_d[j].val << 2;
          trial = sbr_pkg::REMS_W'({sqrt_d[j].root, 2'b01});
          if (sqrt_d[j].rem >= trial) begin
            sqrt_d[j].rem  = sqrt_d[j].rem - trial;
            sqrt_d[j].root = {sqrt_d[j].root[sbr_pkg::ROOT_W-2:0], 1'b1};
          end else begin
            sqrt_d[j].root = {sqrt_d[j].root[sbr_pkg::ROOT_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[StSqrt0+j]) begin
        sqrt_q[j] <= sqrt_d[j];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: round the root, saturate, zero everything on a miss.
  // ---------------------------------------------------------------------------
  logic                               hit_d, hit_q;
  logic signed [sbr_pkg::COORD_W-1:0] hx_d, hx_q, hy_d, hy_q;
  logic [sbr_pkg::DIST_W-1:0]         hd_d, hd_q;

  always_comb begin
    logic [sbr_pkg::ROOT_W:0] rt;
    logic                     rnd;
    rnd = sqrt_q[NumSqrt-1].rem > sbr_pkg::REMS_W'(sqrt_q[NumSqrt-1].root);
    rt  = (sbr_pkg::ROOT_W + 1)'(sqrt_q[NumSqrt-1].root) + rnd;
    hit_d = sqrt_q[NumSqrt-1].found;
    hx_d  = '0;
    hy_d  = '0;
    hd_d  = '0;
    if (sqrt_q[NumSqrt-1].found) begin
      hx_d = sqrt_q[NumSqrt-1].px;
      hy_d = sqrt_q[NumSqrt-1].py;
      hd_d = (rt > (sbr_pkg::ROOT_W + 1)'(sbr_pkg::DIST_MAX)) ? sbr_pkg::DIST_MAX
                                                            : rt[sbr_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[StOut]) begin
      hit_q <= hit_d;
      hx_q  <= hx_d;
      hy_q  <= hy_d;
      hd_q  <= hd_d;
    end
  end

  assign hit_o          = hit_q;
  assign hit_x_o        = hx_q;
  assign hit_y_o        = hy_q;
  assign hit_distance_o = hd_q;

endmodule

// File: src/sbr_checker.sv
module sbr_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic                               hit_o,
  input logic [sbr_pkg::COORD_W-1:0]        hit_x_o,
  input logic [sbr_pkg::COORD_W-1:0]        hit_y_o,
  input logic [sbr_pkg::DIST_W-1:0]         hit_distance_o
);

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_o) &&
      $stable(hit_x_o) && $stable(hit_y_o) && $stable(hit_distance_o))
    else $error("result word changed while stalled");

  // A miss reports a zero point and a zero distance.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !hit_o |-> hit_x_o == '0 && hit_y_o == '0 && hit_distance_o == '0)
    else $error("miss with nonzero point or distance");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk_i)
      !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // When the output stage can move, every stage can move.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled although the output stage is free");

endmodule

bind segment_box_raycast_unit sbr_checker u_sbr_checker (.*);

// File: test/tb.sv
module tb;

  // One query word: a segment, a box and the two group codes.
  typedef struct {
    logic signed [sbr_pkg::COORD_W-1:0] sx, sy, ex, ey, cx, cy;
    logic        [sbr_pkg::SIZE_W-1:0]  w, h;
    logic        [sbr_pkg::GROUP_W-1:0] sgrp, bgrp;
  } query_t;

  // One result word as the block should present it.
  typedef struct {
    logic                               hit;
    logic signed [sbr_pkg::COORD_W-1:0] px, py;
    logic        [sbr_pkg::DIST_W-1:0]  distance;
  } hit_t;

  localparam int unsigned FRAC = sbr_pkg::PARAM_FRAC_BITS_DEF;
  localparam int          NUM_QUERIES = 1900;
  localparam int          CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [sbr_pkg::COORD_W-1:0] start_x_i = '0, start_y_i = '0;
  logic signed [sbr_pkg::COORD_W-1:0] end_x_i = '0, end_y_i = '0;
  logic signed [sbr_pkg::COORD_W-1:0] box_center_x_i = '0, box_center_y_i = '0;
  logic [sbr_pkg::SIZE_W-1:0]  box_width_i = '0, box_height_i = '0;
  logic [sbr_pkg::GROUP_W-1:0] segment_group_i = '0, box_group_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic hit_o;
  logic signed [sbr_pkg::COORD_W-1:0] hit_x_o, hit_y_o;
  logic [sbr_pkg::DIST_W-1:0] hit_distance_o;

  query_t pending_queries[$];
  hit_t   expected_hits[$];
  int     error_count = 0;
  int     cycle_count = 0;
  int     queries_taken = 0;
  bit     query_taken = 1'b0;

  always #5 clk_i = ~clk_i;

  segment_box_raycast_unit dut (.*);

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d (cycle %0d)", what, got, want,
             cycle_count);
    error_count++;
  endtask

  task automatic queue_query(input query_t q);
    pending_queries = {pending_queries, q};
  endtask

  // Parametric crossing of the segment with one box edge, all coordinates in Q.9.
  // On a crossing, ua holds the segment parameter rounded to FRAC fraction bits.
  function automatic bit edge_crossing(input longint x1, y1, x2, y2, x3, y3, x4, y4,
                                       output longint ua);
    longint den, num_a, num_b, rem, quo;
    den   = (y4 - y3) * (x2 - x1) - (x4 - x3) * (y2 - y1);
    num_a = (x4 - x3) * (y1 - y3) - (y4 - y3) * (x1 - x3);
    num_b = (x2 - x1) * (y1 - y3) - (y2 - y1) * (x1 - x3);
    ua = 0;
    // A parallel or degenerate edge never counts as crossed.
    if (den == 0) return 1'b0;
    if (den < 0) begin
      den = -den;
      num_a = -num_a;
      num_b = -num_b;
    end
    // Both parameters have to fall in [0,1], the ends included.
    if (num_a < 0 || num_a > den || num_b < 0 || num_b > den) return 1'b0;
    if (num_a == den) begin
      quo = longint'(1) << (FRAC + 1);
    end else begin
      // Long division with one guard bit, then round half up.
      quo = 0;
      rem = num_a;
      for (int i = 0; i < FRAC + 1; i++) begin
        rem = rem << 1;
        quo = quo << 1;
        if (rem >= den) begin
          rem = rem - den;
          quo = quo | 1;
        end
      end
    end
    ua = (quo + 1) >>> 1;
    return 1'b1;
  endfunction

  // Integer square root rounded to nearest.
  function automatic longint unsigned root_nearest(input longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (s > r) r++;
    return r;
  endfunction

  // Closest crossing of the segment with the box outline, edges taken in tie order.
  function automatic hit_t predict_hit(input query_t q);
    hit_t res;
    longint sx, sy, ex, ey, lft, rgt, top, bot, ua, px, py, dx, dy;
    longint edge_xy[sbr_pkg::NUM_EDGES][4];
    longint unsigned dsq, best, root;
    bit found;
    res = '{hit: 1'b0, px: '0, py: '0, distance: '0};
    if (q.sgrp != q.bgrp) return res;
    sx = q.sx; sy = q.sy; ex = q.ex; ey = q.ey;
    lft = 2 * longint'(q.cx) - longint'(q.w);
    rgt = 2 * longint'(q.cx) + longint'(q.w);
    top = 2 * longint'(q.cy) - longint'(q.h);
    bot = 2 * longint'(q.cy) + longint'(q.h);
    edge_xy[sbr_pkg::EDGE_LEFT]   = '{lft, top, lft, bot};
    edge_xy[sbr_pkg::EDGE_RIGHT]  = '{rgt, top, rgt, bot};
    edge_xy[sbr_pkg::EDGE_TOP]    = '{lft, top, rgt, top};
    edge_xy[sbr_pkg::EDGE_BOTTOM] = '{lft, bot, rgt, bot};
    found = 1'b0;
    best = 0;
    for (int k = 0; k < sbr_pkg::NUM_EDGES; k++) begin
      if (edge_crossing(2 * sx, 2 * sy, 2 * ex, 2 * ey, edge_xy[k][0], edge_xy[k][1],
                        edge_xy[k][2], edge_xy[k][3], ua)) begin
        px = sx + ((ua * (ex - sx) + (longint'(1) << (FRAC - 1))) >>> FRAC);
        py = sy + ((ua * (ey - sy) + (longint'(1) << (FRAC - 1))) >>> FRAC);
        dx = px - sx;
        dy = py - sy;
        dsq = longint'(dx * dx) + longint'(dy * dy);
        // Only a strictly closer point replaces the earlier edge.
        if (!found || dsq < best) begin
          found = 1'b1;
          best = dsq;
          res.px = px[sbr_pkg::COORD_W-1:0];
          res.py = py[sbr_pkg::COORD_W-1:0];
        end
      end
    end
    if (found) begin
      root = root_nearest(best);
      res.hit = 1'b1;
      res.distance = (root > longint'(sbr_pkg::DIST_MAX)) ? sbr_pkg::DIST_MAX
                                                          : root[sbr_pkg::DIST_W-1:0];
    end
    return res;
  endfunction

  function automatic query_t make_query(input longint sx, sy, ex, ey, cx, cy, w, h,
                                       input int sgrp, bgrp);
    query_t q;
    q.sx = sx[sbr_pkg::COORD_W-1:0]; q.sy = sy[sbr_pkg::COORD_W-1:0];
    q.ex = ex[sbr_pkg::COORD_W-1:0]; q.ey = ey[sbr_pkg::COORD_W-1:0];
    q.cx = cx[sbr_pkg::COORD_W-1:0]; q.cy = cy[sbr_pkg::COORD_W-1:0];
    q.w = w[sbr_pkg::SIZE_W-1:0]; q.h = h[sbr_pkg::SIZE_W-1:0];
    q.sgrp = sgrp[sbr_pkg::GROUP_W-1:0]; q.bgrp = bgrp[sbr_pkg::GROUP_W-1:0];
    return q;
  endfunction

  // A coordinate with a random magnitude, so small and huge values both show up.
  function automatic longint spread_coord();
    logic signed [31:0] v;
    v = $urandom;
    return longint'(v >>> $urandom_range(8, 31));
  endfunction

  // A segment placed around a random box so that most of them touch an edge.
  function automatic query_t near_box_query();
    longint cx, cy, w, h, reach;
    int grp;
    cx = spread_coord();
    cy = spread_coord();
    w = $urandom_range(0, 8388607) >> $urandom_range(0, 22);
    h = $urandom_range(0, 8388607) >> $urandom_range(0, 22);
    reach = (w > h ? w : h) + 1;
    grp = $urandom_range(0, 31);
    return make_query(cx + $signed($urandom_range(0, 32'(4 * reach))) - 2 * reach,
                      cy + $signed($urandom_range(0, 32'(4 * reach))) - 2 * reach,
                      cx + $signed($urandom_range(0, 32'(4 * reach))) - 2 * reach,
                      cy + $signed($urandom_range(0, 32'(4 * reach))) - 2 * reach,
                      cx, cy, w, h, grp, ($urandom_range(0, 9) == 0) ? ~grp : grp);
  endfunction

  function automatic query_t raw_query();
    return make_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
  endfunction

  // Monitor: predicts each accepted query and checks each accepted result word.
  always @(posedge clk_i) begin
    hit_t want;
    query_t q;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
    query_taken = rst_ni && in_valid_i && in_ready_o;
    if (query_taken) begin
      q = '{start_x_i, start_y_i, end_x_i, end_y_i, box_center_x_i, box_center_y_i,
            box_width_i, box_height_i, segment_group_i, box_group_i};
      expected_hits = {expected_hits, predict_hit(q)};
      queries_taken++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = expected_hits.pop_front();
        if (hit_o !== want.hit) report_mismatch("hit", hit_o, want.hit);
        if (hit_x_o !== want.px) report_mismatch("hit_x", hit_x_o, want.px);
        if (hit_y_o !== want.py) report_mismatch("hit_y", hit_y_o, want.py);
        if (hit_distance_o !== want.distance)
          report_mismatch("hit_distance", hit_distance_o, want.distance);
      end
    end
  end

  // Driver: both handshakes move on the falling edge. The first third of the run
  // mostly idles the receiver, the second the sender, the last one idles neither.
  always @(negedge clk_i) begin
    int phase;
    bit send_idle, recv_idle;
    phase = queries_taken * 3 / NUM_QUERIES;
    send_idle = (phase == 0) ? ($urandom_range(0, 99) < 11) :
                (phase == 1) ? ($urandom_range(0, 99) < 71) : 1'b0;
    recv_idle = (phase == 0) ? ($urandom_range(0, 99) < 71) :
                (phase == 1) ? ($urandom_range(0, 99) < 11) : 1'b0;
    if (rst_ni) out_ready_i <= !recv_idle;
    if (rst_ni && (!in_valid_i || query_taken)) begin
      if (pending_queries.size() != 0 && !send_idle) begin
        query_t q;
        q = pending_queries.pop_front();
        start_x_i <= q.sx; start_y_i <= q.sy; end_x_i <= q.ex; end_y_i <= q.ey;
        box_center_x_i <= q.cx; box_center_y_i <= q.cy;
        box_width_i <= q.w; box_height_i <= q.h;
        segment_group_i <= q.sgrp; box_group_i <= q.bgrp;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  initial begin
    int drain;
    rst_ni = 1'b0;
    // Box at the origin, 4.0 by 4.0, so its edges sit at +/-2.0 (512 in Q.8).
    queue_query(make_query(-2560, 0, 2560, 0, 0, 0, 1024, 1024, 3, 3));
    queue_query(make_query(-2560, 0, 2560, 0, 0, 0, 1024, 1024, 3, 4));
    // Through a corner: the left and top edges tie and left has to win.
    queue_query(make_query(-2560, -2560, 0, 0, 0, 0, 1024, 1024, 7, 7));
    // Segment ends exactly on the left edge.
    queue_query(make_query(-2560, 0, -512, 0, 0, 0, 1024, 1024, 0, 0));
    // Segment starts exactly on the right edge.
    queue_query(make_query(512, 100, 2560, 100, 0, 0, 1024, 1024, 0, 0));
    // Running along the top edge: collinear there, corners through the sides.
    queue_query(make_query(-2560, -512, 2560, -512, 0, 0, 1024, 1024, 1, 1));
    // Zero-length segment inside the box and a zero-size box under a segment.
    queue_query(make_query(10, 10, 10, 10, 0, 0, 1024, 1024, 2, 2));
    queue_query(make_query(-100, 0, 100, 0, 0, 0, 0, 0, 2, 2));
    // Segment wholly inside and segment missing the box.
    queue_query(make_query(-50, -50, 60, 70, 0, 0, 1024, 1024, 5, 5));
    queue_query(make_query(-2560, 900, 2560, 950, 0, 0, 1024, 1024, 5, 5));
    // Extremes of every field; the far corner box saturates the distance.
    queue_query(make_query(-8388608, -8388608, 8388607, 8388607,
                           8388000, 8388000, 2000, 2000, 31, 31));
    queue_query(make_query(8388607, 8388607, -8388608, -8388608,
                           -8388608, -8388608, 8388607, 8388607, 0, 0));
    queue_query(make_query(-8388608, 0, 8388607, 0, 0, 0,
                           8388607, 8388607, 31, 31));
    queue_query(make_query(8388607, -8388608, 8388607, 8388607,
                           8388607, 0, 0, 8388607, 31, 0));
    queue_query(make_query(0, -8388608, 0, 8388607, 0, 0, 4, 8388607, 16, 16));
    queue_query(make_query(-8388608, -8388608, -8388608, -8388608,
                           -8388608, -8388608, 0, 0, 0, 0));
    while (pending_queries.size() < NUM_QUERIES) begin
      if ($urandom_range(0, 9) < 8) queue_query(near_box_query());
      else queue_query(raw_query());
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    while (pending_queries.size() != 0 || in_valid_i || expected_hits.size() != 0)
      @(posedge clk_i);
    // Give any stray word time to come out after the last expected one.
    for (drain = 0; drain < 60; drain++) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
src/sbr_pkg.sv
src/segment_box_raycast_unit.sv
src/sbr_checker.sv
test/tb.sv
